// File: rtl/rbrl_pkg.sv
// Shared types and constants for the retry backoff report limiter.
package rbrl_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_BLOCKER_RECHECK = 2'd0;
  localparam logic [1:0] REG_MIN_RETRY       = 2'd1;
  localparam logic [1:0] REG_MAX_RETRY       = 2'd2;
  localparam logic [1:0] REG_SUMMARY_INTV    = 2'd3;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Validity limits
  localparam logic [15:0] MIN_RETRY_FLOOR = 16'd5000;
  localparam logic [15:0] RETRY_CEILING   = 16'd60000;
  localparam logic [31:0] HALF_RANGE      = 32'h8000_0000;

  // Register reset values
  localparam logic [31:0] BLOCKER_RECHECK_RST = 32'd30000;
  localparam logic [15:0] MIN_RETRY_RST       = 16'd5000;
  localparam logic [15:0] MAX_RETRY_RST       = 16'd60000;
  localparam logic [31:0] SUMMARY_INTV_RST    = 32'd300000;

  localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  outcome_result;
    logic [2:0]  outcome_snapshot;
    logic [1:0]  outcome_phase;
    logic [3:0]  outcome_reason;
    logic [2:0]  outcome_deep_sleep;
  } in_item_t;

  typedef struct packed {
    logic        attempted;
    logic        transition;
    logic        summary_due;
    logic [31:0] suppressed_count;
  } out_item_t;

  // Outcome result codes that are not failures
  localparam logic [3:0] RES_ENTERED      = 4'd0;
  localparam logic [3:0] RES_NOT_ELIGIBLE = 4'd1;

endpackage

// File: rtl/retry_backoff_report_limiter_top.sv
// Top level of the retry backoff report limiter.
//
// Usage:
// - Input channel (in_valid/in_ready/in_data): one poll transaction carries
//   the current millisecond time and the five-part outcome of an attempt.
// - Result channel (out_valid/out_ready/out_data): exactly one result
//   transaction per poll: attempted, transition, summary_due and the
//   suppressed repeat count (zero unless summary_due is set).
// - Config port (APB-style, pready tied high): four registers at byte
//   addresses 0x0, 0x4, 0x8, 0xC. Write them only while the block is idle.
// Output: each result is registered, in the skid entry if the result register is held.
// Throughput: one poll per cycle unless stalled; the whole update (wrap-safe
//   elapsed compare, doubling with cap, saturating count) is one combinational
//   pass from the accepted poll and state registers into the result register.
// Stall: the result register is backed by a one-entry skid buffer, so a poll
//   is still taken while a result waits; in_ready drops only once the skid
//   entry is occupied, and returns as soon as out_ready drains it.
// Reset (rst_n, synchronous, active low): registers go to their reset
//   values, backoff state is cleared, the interval returns to 5000 ms and
//   both output slots are emptied.
module retry_backoff_report_limiter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // poll channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rbrl_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output rbrl_pkg::out_item_t                 out_data,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rbrl_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rbrl_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rbrl_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // ---------------- configuration registers ----------------
  logic [31:0] blocker_recheck_r;
  logic [15:0] min_retry_r;
  logic [15:0] max_retry_r;
  logic [31:0] summary_intv_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocker_recheck_r <= rbrl_pkg::BLOCKER_RECHECK_RST;
      min_retry_r       <= rbrl_pkg::MIN_RETRY_RST;
      max_retry_r       <= rbrl_pkg::MAX_RETRY_RST;
      summary_intv_r    <= rbrl_pkg::SUMMARY_INTV_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rbrl_pkg::REG_BLOCKER_RECHECK: blocker_recheck_r <= pwdata;
        rbrl_pkg::REG_MIN_RETRY:       min_retry_r       <= pwdata[15:0];
        rbrl_pkg::REG_MAX_RETRY:       max_retry_r       <= pwdata[15:0];
        rbrl_pkg::REG_SUMMARY_INTV:    summary_intv_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rbrl_pkg::REG_BLOCKER_RECHECK: prdata = blocker_recheck_r;
      rbrl_pkg::REG_MIN_RETRY:       prdata = {16'd0, min_retry_r};
      rbrl_pkg::REG_MAX_RETRY:       prdata = {16'd0, max_retry_r};
      rbrl_pkg::REG_SUMMARY_INTV:    prdata = summary_intv_r;
      default:                       prdata = '0;
    endcase
  end

  // All ranges must hold for any attempt to be taken.
  logic cfg_ok;
  assign cfg_ok = (blocker_recheck_r != 32'd0) &&
                  (blocker_recheck_r < rbrl_pkg::HALF_RANGE) &&
                  (min_retry_r >= rbrl_pkg::MIN_RETRY_FLOOR) &&
                  (min_retry_r <= rbrl_pkg::RETRY_CEILING) &&
                  (max_retry_r >= min_retry_r) &&
                  (max_retry_r <= rbrl_pkg::RETRY_CEILING) &&
                  (summary_intv_r >= {16'd0, rbrl_pkg::RETRY_CEILING}) &&
                  (summary_intv_r < rbrl_pkg::HALF_RANGE);

  // ---------------- backoff state ----------------
  logic        has_attempt_r;
  logic [31:0] last_attempt_r;
  logic [31:0] retry_interval_r,  retry_interval_nxt;
  logic        has_prev_r;
  logic [15:0] prev_outcome_r;
  logic [31:0] last_report_r;
  logic [31:0] suppressed_r,      suppressed_nxt;

  logic        in_acc;
  logic [15:0] packed_outcome;
  logic [31:0] since_attempt;
  logic [31:0] since_report;
  logic        attempt_go;
  logic        repeated;
  logic        failure;
  logic [32:0] doubled;
  logic        report_now;
  logic [31:0] count_inc;
  rbrl_pkg::out_item_t result;

  assign in_acc = in_valid && in_ready;

  assign packed_outcome = {in_data.outcome_result, in_data.outcome_snapshot,
                           in_data.outcome_phase, in_data.outcome_reason,
                           in_data.outcome_deep_sleep};

  // Wrap-safe elapsed times (mod 2^32)
  assign since_attempt = in_data.now_ms - last_attempt_r;
  assign since_report  = in_data.now_ms - last_report_r;

  assign attempt_go = cfg_ok && (!has_attempt_r || (since_attempt >= retry_interval_r));
  assign repeated   = has_prev_r && (prev_outcome_r == packed_outcome);
  assign failure    = (in_data.outcome_result != rbrl_pkg::RES_ENTERED) &&
                      (in_data.outcome_result != rbrl_pkg::RES_NOT_ELIGIBLE);

  // Doubling with cap: 2*ri > max covers both "ri >= max" and overflow past max.
  assign doubled = {retry_interval_r, 1'b0};

  always_comb begin
    if (failure) begin
      if (repeated) begin
        if (doubled > {17'd0, max_retry_r}) begin
          retry_interval_nxt = {16'd0, max_retry_r};
        end else begin
          retry_interval_nxt = doubled[31:0];
        end
      end else begin
        retry_interval_nxt = {16'd0, min_retry_r};
      end
    end else begin
      retry_interval_nxt = blocker_recheck_r;
    end
  end

  assign count_inc  = (suppressed_r == rbrl_pkg::COUNT_SAT) ? suppressed_r
                                                            : suppressed_r + 32'd1;
  assign report_now = repeated && (since_report >= summary_intv_r);

  always_comb begin
    if (!repeated || report_now) begin
      suppressed_nxt = 32'd0;
    end else begin
      suppressed_nxt = count_inc;
    end
  end

  always_comb begin
    result = '0;
    if (attempt_go) begin
      result.attempted   = 1'b1;
      result.transition  = !repeated;
      result.summary_due = report_now;
      if (report_now) begin
        result.suppressed_count = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_attempt_r    <= 1'b0;
      last_attempt_r   <= '0;
      retry_interval_r <= {16'd0, rbrl_pkg::MIN_RETRY_RST};
      has_prev_r       <= 1'b0;
      prev_outcome_r   <= '0;
      last_report_r    <= '0;
      suppressed_r     <= '0;
    end else if (in_acc && attempt_go) begin
      has_attempt_r    <= 1'b1;
      last_attempt_r   <= in_data.now_ms;
      retry_interval_r <= retry_interval_nxt;
      has_prev_r       <= 1'b1;
      prev_outcome_r   <= packed_outcome;
      suppressed_r     <= suppressed_nxt;
      if (!repeated || report_now) begin
        last_report_r <= in_data.now_ms;
      end
    end
  end

  // ---------------- result register + skid ----------------
  logic                out_valid_r;
  rbrl_pkg::out_item_t out_r;
  logic                skid_valid_r;
  rbrl_pkg::out_item_t skid_r;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      // output slot frees up this cycle
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= result;
      end
    end else if (in_acc) begin
      skid_r <= result;
    end
  end

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_count_only_on_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.summary_due) |-> (out_r.suppressed_count == 32'd0))
    else $error("suppressed count reported without summary");

  a_flags_need_attempt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.transition || out_r.summary_due)) |-> out_r.attempted)
    else $error("transition or summary without attempt");

  a_interval_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && attempt_go) |=> $stable(retry_interval_r))
    else $error("retry interval changed without an attempt");

  a_summary_is_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.summary_due) |-> !out_r.transition)
    else $error("summary reported on a new outcome");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the retry backoff report limiter top level.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // Long receiver hold-off: starts once this many polls are in.
  localparam int unsigned HOLD_AFTER = 400;
  localparam int unsigned HOLD_CYCLES = 80;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready a quarter of the time on average
    RX_SQUARE   // ready and stalled in equal stretches, in turn
  } rx_mode_t;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  rbrl_pkg::in_item_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  rbrl_pkg::out_item_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rbrl_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [rbrl_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [rbrl_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  retry_backoff_report_limiter_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the configuration registers (reset values) and of the limiter
  // state. Config writes only happen while the block is idle, so the shadow
  // can be updated at the moment the write task issues them.
  // ---------------------------------------------------------------------------
  logic [31:0] sh_blocker = rbrl_pkg::BLOCKER_RECHECK_RST;
  logic [15:0] sh_min     = rbrl_pkg::MIN_RETRY_RST;
  logic [15:0] sh_max     = rbrl_pkg::MAX_RETRY_RST;
  logic [31:0] sh_summary = rbrl_pkg::SUMMARY_INTV_RST;

  logic        st_has_attempt  = 1'b0;
  logic [31:0] st_last_attempt = '0;
  logic [31:0] st_interval     = {16'd0, rbrl_pkg::MIN_RETRY_RST};
  logic        st_has_prev     = 1'b0;
  logic [15:0] st_prev_key     = '0;
  logic [31:0] st_last_report  = '0;
  logic [31:0] st_suppressed   = '0;

  rbrl_pkg::in_item_t  poll_q[$];     // polls waiting for the driver
  rbrl_pkg::out_item_t verdict_q[$];  // predicted results, oldest first

  int unsigned n_polls_taken = 0;
  int unsigned n_err = 0;
  int unsigned cycle_cnt = 0;
  logic in_fire = 1'b0;

  // Stimulus cursor: running clock time and the current outcome
  logic [31:0] cur_now = '0;
  rbrl_pkg::in_item_t cur_oc = '0;

  // Wrap-safe elapsed time, modulo 2^32
  function automatic logic [31:0] ms_since(logic [31:0] now, logic [31:0] from);
    return now - from;
  endfunction

  // Backoff and report-suppression update for one accepted poll
  function automatic rbrl_pkg::out_item_t backoff_step(rbrl_pkg::in_item_t p);
    rbrl_pkg::out_item_t r;
    logic [15:0] key;
    logic [31:0] cap;
    logic cfg_ok;
    logic repeated;
    r = '0;
    key = {p.outcome_result, p.outcome_snapshot, p.outcome_phase,
           p.outcome_reason, p.outcome_deep_sleep};
    cap = {16'd0, sh_max};
    cfg_ok = sh_blocker != 32'd0 && sh_blocker < rbrl_pkg::HALF_RANGE &&
             sh_min >= rbrl_pkg::MIN_RETRY_FLOOR && sh_min <= rbrl_pkg::RETRY_CEILING &&
             sh_max >= sh_min && sh_max <= rbrl_pkg::RETRY_CEILING &&
             sh_summary >= {16'd0, rbrl_pkg::RETRY_CEILING} &&
             sh_summary < rbrl_pkg::HALF_RANGE;
    // Invalid config or interval not yet elapsed: no attempt, all zero
    if (!cfg_ok) return r;
    if (st_has_attempt && ms_since(p.now_ms, st_last_attempt) < st_interval) return r;

    repeated = st_has_prev && st_prev_key == key;
    st_last_attempt = p.now_ms;
    st_has_attempt = 1'b1;

    if (p.outcome_result != rbrl_pkg::RES_ENTERED &&
        p.outcome_result != rbrl_pkg::RES_NOT_ELIGIBLE) begin
      if (repeated) begin
        // interval may sit above the cap after a register write
        if (st_interval >= cap || st_interval > cap - st_interval) st_interval = cap;
        else st_interval = st_interval << 1;
      end else begin
        st_interval = {16'd0, sh_min};
      end
    end else begin
      st_interval = sh_blocker;
    end

    if (!repeated) begin
      st_last_report = p.now_ms;
      st_suppressed = '0;
    end else begin
      if (st_suppressed != rbrl_pkg::COUNT_SAT) st_suppressed = st_suppressed + 32'd1;
      if (ms_since(p.now_ms, st_last_report) >= sh_summary) begin
        r.summary_due = 1'b1;
        r.suppressed_count = st_suppressed;
        st_suppressed = '0;
        st_last_report = p.now_ms;
      end
    end
    st_prev_key = key;
    st_has_prev = 1'b1;

    r.attempted = 1'b1;
    r.transition = !repeated;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Results are checked
  // before the new poll's prediction is queued, as each result is registered.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rbrl_pkg::out_item_t exp_r;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result transaction with no poll outstanding");
          n_err++;
        end else begin
          exp_r = verdict_q.pop_front();
          check_field("attempted", 32'(exp_r.attempted), 32'(out_data.attempted));
          check_field("transition", 32'(exp_r.transition), 32'(out_data.transition));
          check_field("summary_due", 32'(exp_r.summary_due), 32'(out_data.summary_due));
          check_field("suppressed_count", exp_r.suppressed_count,
                      out_data.suppressed_count);
        end
      end
      if (in_valid && in_ready) begin
        verdict_q = {verdict_q, backoff_step(in_data)};
        n_polls_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. The payload
  // only moves after the previous transaction was taken.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (poll_q.size() > 0) begin
        in_data <= poll_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          // no gap at all now and then, so back-to-back streams happen too
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a stall pattern redrawn at random when its mode counter runs out,
  // plus one long hold-off so the skid buffer fills and in_ready drops.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && n_polls_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = cycle_cnt[2];
      endcase
    end
    out_ready <= rdy;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Config write: setup cycle then access cycle; the register takes the
  // value at the edge where psel, penable, pwrite and pready are all high.
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    case (idx)
      rbrl_pkg::REG_BLOCKER_RECHECK: sh_blocker = val;
      rbrl_pkg::REG_MIN_RETRY:       sh_min = val[15:0];
      rbrl_pkg::REG_MAX_RETRY:       sh_max = val[15:0];
      default:                       sh_summary = val;
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_poll(logic [31:0] now, logic [3:0] res, logic [2:0] snap,
                           logic [1:0] ph, logic [3:0] rsn, logic [2:0] ds);
    rbrl_pkg::in_item_t p;
    p.now_ms = now;
    p.outcome_result = res;
    p.outcome_snapshot = snap;
    p.outcome_phase = ph;
    p.outcome_reason = rsn;
    p.outcome_deep_sleep = ds;
    poll_q = {poll_q, p};
  endtask

  // Random polls: mostly the same outcome again with time moving by roughly
  // an interval, so backoff doubling and summaries are reached; the rest are
  // result changes, single-field changes and fully random outcomes.
  task automatic gen_polls(int unsigned n);
    int unsigned r;
    logic [31:0] step;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) step = $urandom_range(0, 2000);
      else if (r < 70) step = $urandom_range(4000, 70000);
      else if (r < 88) step = $urandom_range(60000, 700000);
      else step = $urandom;
      cur_now = cur_now + step;

      r = $urandom_range(0, 99);
      if (r < 62) begin
        // same outcome again
      end else if (r < 76) begin
        cur_oc.outcome_result = 4'($urandom_range(0, 15));
      end else if (r < 90) begin
        case ($urandom_range(0, 3))
          0: cur_oc.outcome_snapshot = 3'($urandom_range(0, 7));
          1: cur_oc.outcome_phase = 2'($urandom_range(0, 3));
          2: cur_oc.outcome_reason = 4'($urandom_range(0, 15));
          default: cur_oc.outcome_deep_sleep = 3'($urandom_range(0, 7));
        endcase
      end else begin
        cur_oc = rbrl_pkg::in_item_t'($urandom);
      end
      push_poll(cur_now, cur_oc.outcome_result, cur_oc.outcome_snapshot,
                cur_oc.outcome_phase, cur_oc.outcome_reason, cur_oc.outcome_deep_sleep);
    end
  endtask

  // Wait until every poll went in and every result came out, with some margin.
  task automatic drain;
    while (poll_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One configuration setting and its stream of polls. The 16-bit registers
  // get junk in the upper half of the write data; only the low half counts.
  task automatic run_phase(logic [31:0] blk, logic [15:0] mn, logic [15:0] mx,
                           logic [31:0] sm, int unsigned n);
    cfg_write(rbrl_pkg::REG_BLOCKER_RECHECK, blk);
    cfg_write(rbrl_pkg::REG_MIN_RETRY, {16'($urandom), mn});
    cfg_write(rbrl_pkg::REG_MAX_RETRY, {16'($urandom), mx});
    cfg_write(rbrl_pkg::REG_SUMMARY_INTV, sm);
    gen_polls(n);
    drain();
  endtask

  initial begin
    logic [15:0] mn;
    cur_oc = rbrl_pkg::in_item_t'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset configuration (5 s min, 60 s cap, 300 s summary)
    push_poll(32'd0,      4'd2, 3'd1, 2'd1, 4'd3, 3'd2);  // first attempt
    push_poll(32'd100,    4'd2, 3'd1, 2'd1, 4'd3, 3'd2);  // too early
    push_poll(32'd5000,   4'd2, 3'd1, 2'd1, 4'd3, 3'd2);  // repeat, doubles
    push_poll(32'd15000,  4'd2, 3'd1, 2'd1, 4'd3, 3'd2);
    push_poll(32'd35000,  4'd2, 3'd1, 2'd1, 4'd3, 3'd2);
    push_poll(32'd75000,  4'd2, 3'd1, 2'd1, 4'd3, 3'd2);  // hits the cap
    push_poll(32'd135000, 4'd2, 3'd1, 2'd1, 4'd3, 3'd2);  // stays at cap
    push_poll(32'd300000, 4'd2, 3'd1, 2'd1, 4'd3, 3'd2);  // summary due
    push_poll(32'd360000, 4'd0, 3'd0, 2'd2, 4'd0, 3'd0);  // entered
    push_poll(32'd390000, 4'd0, 3'd0, 2'd2, 4'd0, 3'd0);  // entered again
    push_poll(32'd420000, 4'd1, 3'd5, 2'd1, 4'd9, 3'd6);  // not eligible
    push_poll(32'd450000, 4'd15, 3'd7, 2'd3, 4'd15, 3'd7); // out-of-range codes
    push_poll(32'd455000, 4'd9, 3'd4, 2'd0, 4'd12, 3'd1); // new failure kind
    push_poll(32'd460000, 4'd9, 3'd4, 2'd0, 4'd12, 3'd5); // deep sleep differs
    push_poll(32'hFFFF_F000, 4'd9, 3'd4, 2'd0, 4'd12, 3'd5); // long gap, summary
    push_poll(32'h0000_0388, 4'd9, 3'd4, 2'd0, 4'd12, 3'd5); // across wrap, early
    push_poll(32'h0000_2328, 4'd9, 3'd4, 2'd0, 4'd12, 3'd5); // across wrap, due
    push_poll(32'h7FFF_FFFF, 4'd0, 3'd0, 2'd0, 4'd0, 3'd0);
    push_poll(32'hFFFF_FFFF, 4'd0, 3'd0, 2'd0, 4'd0, 3'd0);
    push_poll(32'h0000_0000, 4'd8, 3'd3, 2'd3, 4'd1, 3'd4);
    drain();
    cur_now = 32'h0000_0000;

    // Valid settings, low and high extremes first
    run_phase(32'd1,          16'd5000,  16'd5000,  32'd60000,    180);
    run_phase(32'h7FFF_FFFF,  16'd60000, 16'd60000, 32'h7FFF_FFFF, 150);
    run_phase(32'd30000,      16'd5000,  16'd60000, 32'd60000,    200);
    // Cap pulled below an interval that may already be large
    run_phase(32'd30000,      16'd5000,  16'd5000,  32'd60000,    100);

    // Each register out of range, at or beyond its limit: nothing is ever attempted
    run_phase(32'd0,          16'd5000,  16'd60000, 32'd300000,   20);
    run_phase(32'h8000_0000,  16'd5000,  16'd60000, 32'd300000,   20);
    run_phase(32'hFFFF_FFFF,  16'd5000,  16'd60000, 32'd300000,   15);
    run_phase(32'd30000,      16'd4999,  16'd60000, 32'd300000,   15);
    run_phase(32'd30000,      16'd0,     16'd60000, 32'd300000,   15);
    run_phase(32'd30000,      16'd60001, 16'd60001, 32'd300000,   15);
    run_phase(32'd30000,      16'd20000, 16'd19999, 32'd300000,   15);
    run_phase(32'd30000,      16'd5000,  16'd65535, 32'd300000,   15);
    run_phase(32'd30000,      16'd5000,  16'd60000, 32'd59999,    15);
    run_phase(32'd30000,      16'd5000,  16'd60000, 32'h8000_0000, 15);
    run_phase(32'd30000,      16'd5000,  16'd60000, 32'hFFFF_FFFF, 15);

    // Random valid settings
    for (int k = 0; k < 5; k++) begin
      mn = 16'($urandom_range(5000, 60000));
      run_phase($urandom_range(1, 200000), mn, 16'($urandom_range(mn, 60000)),
                $urandom_range(60000, 2000000), 205);
    end

    repeat (5) @(posedge clk);
    if (n_err == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
